FILE: rtl/lcse_pkg.sv
// shared types and constants for the line compressed-size estimator
// no dependencies; imported by every module of the block
package lcse_pkg;

  localparam int WORDS_PER_BLOCK = 8;
  localparam int MAX_TARGETS     = 4;

  localparam int CNT_W   = $clog2(WORDS_PER_BLOCK);
  localparam int N_W     = $clog2(WORDS_PER_BLOCK + 1);
  localparam int TOTAL_W = 10;
  localparam int SIZE_W  = 7;
  localparam int TGT_W   = 6;
  localparam int SLOT_W  = 2;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 3;
  localparam int IDX_W   = 3;
  localparam int LANE_W  = 6;

  localparam logic [LANE_W-1:0] PREFIX_BITS = 6'd3;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_SIZE_MODE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_TARGET_COUNT = 3'd1;
  localparam logic [IDX_W-1:0] REG_TARGET_0     = 3'd2;
  localparam logic [IDX_W-1:0] REG_TARGET_END   = IDX_W'(2 + MAX_TARGETS);

  // size_mode codes, any other code selects the minimum of both
  localparam logic [MODE_W-1:0] MODE_FPC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BDI = 2'd1;

  typedef struct packed {
    logic [LANE_W-1:0] bits;
    logic [15:0]       min16;
    logic [15:0]       max16;
  } lane_t;

  typedef struct packed {
    logic [N_W-1:0]     n;
    logic [TOTAL_W-1:0] fpc_total;
    logic               all_zero;
    logic               uniform;
    logic [63:0]        min64;
    logic [63:0]        max64;
    logic [31:0]        min32;
    logic [31:0]        max32;
    logic [15:0]        min16;
    logic [15:0]        max16;
  } snap_t;

  typedef struct packed {
    logic [MODE_W-1:0]                  size_mode;
    logic [COUNT_W-1:0]                 target_count;
    logic [MAX_TARGETS-1:0][TGT_W-1:0]  tgt_size;
  } cfg_t;

endpackage

FILE: rtl/lcse_lane.sv
// one 32-bit lane: frequent-pattern bit count plus min/max of its 16-bit halves
// depends on lcse_pkg
module lcse_lane (
  input  logic [31:0]    half,
  output lcse_pkg::lane_t info
);
  import lcse_pkg::*;

  logic              fits4, fits8, fits16, bytes_eq, lo_zero, hb0, hb1;
  logic [LANE_W-1:0] payload;

  assign fits4    = (&half[31:3]) || ~(|half[31:3]);
  assign fits8    = (&half[31:7]) || ~(|half[31:7]);
  assign fits16   = (&half[31:15]) || ~(|half[31:15]);
  assign bytes_eq = (half[31:24] == half[7:0]) && (half[23:16] == half[7:0]) &&
                    (half[15:8] == half[7:0]);
  assign lo_zero  = (half[15:0] == 16'h0000);
  // each halfword is a sign-extended byte
  assign hb0      = (&half[15:7]) || ~(|half[15:7]);
  assign hb1      = (&half[31:23]) || ~(|half[31:23]);

  always_comb begin
    if (half == 32'h0) begin
      payload = 6'd0;
    end else if (fits4) begin
      payload = 6'd4;
    end else if (bytes_eq || fits8) begin
      payload = 6'd8;
    end else if (fits16 || lo_zero || (hb0 && hb1)) begin
      payload = 6'd16;
    end else begin
      payload = 6'd32;
    end
  end

  assign info.bits  = payload + PREFIX_BITS;
  assign info.min16 = (half[15:0] < half[31:16]) ? half[15:0] : half[31:16];
  assign info.max16 = (half[15:0] > half[31:16]) ? half[15:0] : half[31:16];

endmodule

FILE: rtl/lcse_accum.sv
// per-block running state: two lanes feed the bit total and the min/max trackers
// depends on lcse_pkg and lcse_lane
module lcse_accum (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [63:0]     data_word,
  input  logic            last_word,
  output logic            close,
  output lcse_pkg::snap_t snap
);
  import lcse_pkg::*;

  logic [CNT_W-1:0]   word_counter;
  logic [TOTAL_W-1:0] fpc_bit_total;
  logic               all_zero_mark;
  logic               uniform_mark;
  logic [63:0]        first_word_value;
  logic [63:0]        min64, max64;
  logic [31:0]        min32, max32;
  logic [15:0]        min16, max16;

  lane_t              lane [2];
  logic               first;
  logic [31:0]        lo, hi, w_min32, w_max32;
  logic [15:0]        w_min16, w_max16;
  logic [N_W-1:0]     n;

  assign lo = data_word[31:0];
  assign hi = data_word[63:32];

  lcse_lane u_lane_lo (.half(lo), .info(lane[0]));
  lcse_lane u_lane_hi (.half(hi), .info(lane[1]));

  assign first   = (word_counter == '0);
  assign n       = N_W'(word_counter) + N_W'(1);
  assign close   = last_word || (n == N_W'(WORDS_PER_BLOCK));

  // merge the lanes before folding into the trackers
  assign w_min32 = (lo < hi) ? lo : hi;
  assign w_max32 = (lo > hi) ? lo : hi;
  assign w_min16 = (lane[0].min16 < lane[1].min16) ? lane[0].min16 : lane[1].min16;
  assign w_max16 = (lane[0].max16 > lane[1].max16) ? lane[0].max16 : lane[1].max16;

  always_comb begin
    snap.n         = n;
    snap.fpc_total = (first ? '0 : fpc_bit_total) + TOTAL_W'(lane[0].bits) +
                     TOTAL_W'(lane[1].bits);
    snap.all_zero  = (first || all_zero_mark) && (data_word == 64'h0);
    snap.uniform   = first || (uniform_mark && (data_word == first_word_value));
    snap.min64     = (first || data_word < min64) ? data_word : min64;
    snap.max64     = (first || data_word > max64) ? data_word : max64;
    snap.min32     = (first || w_min32 < min32) ? w_min32 : min32;
    snap.max32     = (first || w_max32 > max32) ? w_max32 : max32;
    snap.min16     = (first || w_min16 < min16) ? w_min16 : min16;
    snap.max16     = (first || w_max16 > max16) ? w_max16 : max16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_counter  <= '0;
      fpc_bit_total <= '0;
      all_zero_mark <= 1'b1;
      uniform_mark  <= 1'b1;
    end else if (fire) begin
      word_counter  <= close ? '0 : n[CNT_W-1:0];
      fpc_bit_total <= snap.fpc_total;
      all_zero_mark <= snap.all_zero;
      uniform_mark  <= snap.uniform;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (first) begin
        first_word_value <= data_word;
      end
      min64 <= snap.min64;
      max64 <= snap.max64;
      min32 <= snap.min32;
      max32 <= snap.max32;
      min16 <= snap.min16;
      max16 <= snap.max16;
    end
  end

endmodule

FILE: rtl/lcse_final.sv
// closing pipeline: spans, FPC/BDI sizes, mode select, target quantization
// depends on lcse_pkg; fed by lcse_accum through the top level
module lcse_final (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           snap_valid,
  input  lcse_pkg::snap_t                snap,
  output logic                           snap_ready,
  input  lcse_pkg::cfg_t                 cfg,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [lcse_pkg::SIZE_W-1:0]    enc_size,
  output logic [lcse_pkg::SIZE_W-1:0]    alloc_size,
  output logic [lcse_pkg::SLOT_W-1:0]    target_slot,
  output logic                           fits_target
);
  import lcse_pkg::*;

  function automatic logic [SIZE_W-1:0] min_sz(input logic [SIZE_W-1:0] a,
                                               input logic [SIZE_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic ready_b, ready_c, ready_o;
  logic valid_a, valid_b, valid_c;

  // stage a: closed block snapshot
  snap_t a_snap;

  // stage b: span flags and fpc size
  logic [N_W-1:0]    b_n;
  logic [SIZE_W-1:0] b_blk, b_fpc;
  logic              b_zero, b_equal;
  logic              b_s64_8, b_s64_16, b_s64_32, b_s32_8, b_s32_16, b_s16_8;

  // stage c: selected encoded size
  logic [SIZE_W-1:0] c_blk, c_enc;

  logic [63:0]       s64;
  logic [31:0]       s32;
  logic [15:0]       s16;
  logic [SIZE_W-1:0] a_blk, fpc_bytes, bdi, n7, enc_next;
  logic [TOTAL_W:0]  fpc_round;
  logic [COUNT_W-1:0] cnt;
  logic [MAX_TARGETS-1:0] usable;
  logic [SIZE_W-1:0] alloc_next;
  logic [SLOT_W-1:0] slot_next;
  logic              found;

  assign ready_o    = !result_valid || !result_stall;
  assign ready_c    = !valid_c || ready_o;
  assign ready_b    = !valid_b || ready_c;
  assign snap_ready = !valid_a || ready_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a      <= 1'b0;
      valid_b      <= 1'b0;
      valid_c      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      valid_a      <= (snap_valid && snap_ready) || (valid_a && !ready_b);
      valid_b      <= (valid_a && ready_b) || (valid_b && !ready_c);
      valid_c      <= (valid_b && ready_c) || (valid_c && !ready_o);
      result_valid <= (valid_c && ready_o) || (result_valid && result_stall);
    end
  end

  // stage b logic
  assign s64       = a_snap.max64 - a_snap.min64;
  assign s32       = a_snap.max32 - a_snap.min32;
  assign s16       = a_snap.max16 - a_snap.min16;
  assign a_blk     = {a_snap.n, 3'b000};
  assign fpc_round = {1'b0, a_snap.fpc_total} + (TOTAL_W + 1)'(7);
  assign fpc_bytes = min_sz(SIZE_W'(fpc_round >> 3), a_blk);

  // stage c logic
  assign n7 = SIZE_W'(b_n);
  always_comb begin
    bdi = b_blk;
    if (b_zero)   bdi = 7'd1;
    if (b_equal)  bdi = min_sz(bdi, 7'd8);
    if (b_s64_8)  bdi = min_sz(bdi, 7'd8 + n7);
    if (b_s64_16) bdi = min_sz(bdi, 7'd8 + (n7 << 1));
    if (b_s64_32) bdi = min_sz(bdi, 7'd8 + (n7 << 2));
    if (b_s32_8)  bdi = min_sz(bdi, 7'd4 + (n7 << 1));
    if (b_s32_16) bdi = min_sz(bdi, 7'd4 + (n7 << 2));
    if (b_s16_8)  bdi = min_sz(bdi, 7'd2 + (n7 << 2));
    case (cfg.size_mode)
      MODE_FPC: enc_next = b_fpc;
      MODE_BDI: enc_next = bdi;
      default:  enc_next = min_sz(b_fpc, bdi);
    endcase
  end

  // output stage: first usable slot in order wins
  assign cnt = (cfg.target_count > COUNT_W'(MAX_TARGETS)) ? COUNT_W'(MAX_TARGETS)
                                                          : cfg.target_count;
  always_comb begin
    for (int i = 0; i < MAX_TARGETS; i++) begin
      usable[i] = (COUNT_W'(i) < cnt) &&
                  (SIZE_W'(cfg.tgt_size[i]) < c_blk) &&
                  (c_enc <= SIZE_W'(cfg.tgt_size[i]));
    end
    found      = (c_enc < c_blk) && (|usable);
    alloc_next = c_blk;
    slot_next  = '0;
    if (c_enc < c_blk) begin
      for (int i = MAX_TARGETS - 1; i >= 0; i--) begin
        if (usable[i]) begin
          alloc_next = SIZE_W'(cfg.tgt_size[i]);
          slot_next  = SLOT_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      a_snap <= snap;
    end
    if (valid_a && ready_b) begin
      b_n      <= a_snap.n;
      b_blk    <= a_blk;
      b_fpc    <= fpc_bytes;
      b_zero   <= a_snap.all_zero;
      b_equal  <= a_snap.uniform;
      b_s64_8  <= (s64[63:8] == '0);
      b_s64_16 <= (s64[63:16] == '0);
      b_s64_32 <= (s64[63:32] == '0);
      b_s32_8  <= (s32[31:8] == '0);
      b_s32_16 <= (s32[31:16] == '0);
      b_s16_8  <= (s16[15:8] == '0);
    end
    if (valid_b && ready_c) begin
      c_blk <= b_blk;
      c_enc <= enc_next;
    end
    if (valid_c && ready_o) begin
      enc_size    <= c_enc;
      alloc_size  <= alloc_next;
      target_slot <= slot_next;
      fits_target <= found;
    end
  end

  a_fits_covers_enc: assert property (@(posedge clk) disable iff (rst)
    result_valid && fits_target |-> enc_size <= alloc_size)
    else $error("chosen target smaller than encoded size");

  a_enc_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (enc_size != '0) && (enc_size <= 7'd64))
    else $error("encoded size out of range");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !fits_target |-> target_slot == '0)
    else $error("slot set without a target");

  a_snap_hold: assert property (@(posedge clk) disable iff (rst)
    valid_a && !ready_b |=> valid_a && $stable(a_snap))
    else $error("held snapshot changed");

endmodule

FILE: rtl/line_compressed_size_estimator.sv
// Compressed-size estimator for one memory block (FPC and base-delta sizing).
// Word channel: word_valid/word_stall carry data_word (byte zero in bits 7:0) and
// last_word; a transfer happens when word_valid is high and word_stall is low.
// One word per unstalled cycle; a block ends on last_word or after eight words.
// Result channel: result_valid/result_stall carry enc_size, alloc_size,
// target_slot and fits_target, one result per block, none for other words.
// From the transfer of the block's closing word the result passes the snapshot,
// span compare, size select and target select registers.
// Throughput: one word per cycle while word_stall is low, set by the per-word
// tracker update; blocks may follow one another back to back.
// While the receiver stalls, the shown result and up to three closed blocks
// behind it wait; once the snapshot stage is full and cannot move on,
// word_stall rises for every word until the receiver takes a result.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// registers are read after a block closes, write them only while idle.
// Reset (rst, synchronous): empty pipeline, block state cleared, size_mode 0,
// target_count 0, all target sizes 1.
// depends on lcse_pkg, lcse_accum, lcse_final
module line_compressed_size_estimator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         word_valid,
  output logic                         word_stall,
  input  logic [63:0]                  data_word,
  input  logic                         last_word,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [lcse_pkg::SIZE_W-1:0]  enc_size,
  output logic [lcse_pkg::SIZE_W-1:0]  alloc_size,
  output logic [lcse_pkg::SLOT_W-1:0]  target_slot,
  output logic                         fits_target,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lcse_pkg::IDX_W-1:0]   cfg_index,
  input  logic [lcse_pkg::TGT_W-1:0]   cfg_data
);
  import lcse_pkg::*;

  cfg_t  cfg;
  snap_t snap;
  logic  word_fire, close, snap_ready;

  assign cfg_ready  = 1'b1;
  assign word_stall = !snap_ready;
  assign word_fire  = word_valid && !word_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_mode    <= MODE_FPC;
      cfg.target_count <= '0;
      for (int i = 0; i < MAX_TARGETS; i++) begin
        cfg.tgt_size[i] <= TGT_W'(1);
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZE_MODE:    cfg.size_mode    <= cfg_data[MODE_W-1:0];
        REG_TARGET_COUNT: cfg.target_count <= cfg_data[COUNT_W-1:0];
        default: begin
          if (cfg_index >= REG_TARGET_0 && cfg_index < REG_TARGET_END) begin
            cfg.tgt_size[SLOT_W'(cfg_index - REG_TARGET_0)] <= cfg_data;
          end
        end
      endcase
    end
  end

  lcse_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .fire      (word_fire),
    .data_word (data_word),
    .last_word (last_word),
    .close     (close),
    .snap      (snap)
  );

  lcse_final u_final (
    .clk          (clk),
    .rst          (rst),
    .snap_valid   (word_fire && close),
    .snap         (snap),
    .snap_ready   (snap_ready),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .enc_size     (enc_size),
    .alloc_size   (alloc_size),
    .target_slot  (target_slot),
    .fits_target  (fits_target)
  );

endmodule

FILE: test/tb_top.sv
// testbench for line_compressed_size_estimator: directed and random memory blocks
// a built-in size predictor checks every result; depends on lcse_pkg and the block's RTL
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lcse_pkg::*;

  localparam logic [MODE_W-1:0] MODE_MIN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE_TICKS = 8;

  typedef struct packed {
    logic [SIZE_W-1:0] enc;
    logic [SIZE_W-1:0] alloc;
    logic [SLOT_W-1:0] slot;
    logic              fits;
  } size_result_t;

  typedef enum int {
    K_ZERO, K_EQUAL, K_DELTA, K_LANE32, K_LANE16, K_PATTERN, K_NOISE
  } word_kind_e;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                word_valid = 1'b0;
  logic                word_stall;
  logic [63:0]         data_word = '0;
  logic                last_word = 1'b0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [SIZE_W-1:0]   enc_size;
  logic [SIZE_W-1:0]   alloc_size;
  logic [SLOT_W-1:0]   target_slot;
  logic                fits_target;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [TGT_W-1:0]    cfg_data = '0;

  int send_idle_pct = 12;
  int recv_idle_pct = 57;
  int error_count = 0;

  // predictor copy of the registers
  logic [MODE_W-1:0]  cfg_mode = MODE_FPC;
  logic [COUNT_W-1:0] cfg_count = '0;
  logic [TGT_W-1:0]   cfg_target [MAX_TARGETS] = '{default: 6'd1};

  // predictor copy of the block trackers
  int          blk_words = 0;
  int          fpc_bits = 0;
  bit          blk_zero = 1'b1;
  bit          blk_equal = 1'b1;
  logic [63:0] first_word = '0;
  logic [63:0] min64 = '0, max64 = '0;
  logic [31:0] min32 = '0, max32 = '0;
  logic [15:0] min16 = '0, max16 = '0;

  size_result_t expected_sizes[$];

  line_compressed_size_estimator dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) result_stall <= ($urandom_range(99) < recv_idle_pct);

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 50) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  function automatic int min_int(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic bit fits_signed(input logic [31:0] v, input int n);
    int s;
    s = int'(v);
    return (s >= -(1 << (n - 1))) && (s < (1 << (n - 1)));
  endfunction

  function automatic bit half_is_byte(input logic [15:0] h);
    return (h <= 16'h007f) || (h >= 16'hff80);
  endfunction

  // frequent-pattern payload width of one 32-bit word
  function automatic int pattern_bits(input logic [31:0] v);
    if (v == '0) return 0;
    if (fits_signed(v, 4)) return 4;
    if (v[15:8] == v[7:0] && v[23:16] == v[7:0] && v[31:24] == v[7:0]) return 8;
    if (fits_signed(v, 8)) return 8;
    if (fits_signed(v, 16)) return 16;
    if (v[15:0] == '0) return 16;
    if (half_is_byte(v[15:0]) && half_is_byte(v[31:16])) return 16;
    return 32;
  endfunction

  // updates the trackers for one word; at block close works out the sizes
  task automatic predict_word(input logic [63:0] w, input logic mark);
    logic [31:0]  h32 [2];
    logic [15:0]  h16 [4];
    logic [63:0]  s64;
    logic [31:0]  s32;
    logic [15:0]  s16;
    int           n, blk, fpc, bdi, enc, alloc, slot, cnt;
    bit           found;
    size_result_t res;
    h32 = '{w[31:0], w[63:32]};
    h16 = '{w[15:0], w[31:16], w[47:32], w[63:48]};
    if (blk_words == 0) begin
      first_word = w;
      min64 = w; max64 = w;
      min32 = w[31:0]; max32 = w[31:0];
      min16 = w[15:0]; max16 = w[15:0];
      blk_zero = 1'b1;
      blk_equal = 1'b1;
      fpc_bits = 0;
    end
    if (w != '0) blk_zero = 1'b0;
    if (w != first_word) blk_equal = 1'b0;
    if (w < min64) min64 = w;
    if (w > max64) max64 = w;
    foreach (h32[i]) begin
      if (h32[i] < min32) min32 = h32[i];
      if (h32[i] > max32) max32 = h32[i];
    end
    foreach (h16[i]) begin
      if (h16[i] < min16) min16 = h16[i];
      if (h16[i] > max16) max16 = h16[i];
    end
    fpc_bits += 2 * int'(PREFIX_BITS) + pattern_bits(w[31:0]) + pattern_bits(w[63:32]);
    blk_words++;
    if (!mark && blk_words < WORDS_PER_BLOCK) return;

    n = blk_words;
    blk = 8 * n;
    fpc = min_int((fpc_bits + 7) / 8, blk);
    bdi = blk;
    if (blk_zero) bdi = 1;
    if (blk_equal) bdi = min_int(bdi, 8);
    s64 = max64 - min64;
    s32 = max32 - min32;
    s16 = max16 - min16;
    if (s64 <= 64'hff) bdi = min_int(bdi, 8 + n);
    if (s64 <= 64'hffff) bdi = min_int(bdi, 8 + 2 * n);
    if (s64 <= 64'hffff_ffff) bdi = min_int(bdi, 8 + 4 * n);
    if (s32 <= 32'hff) bdi = min_int(bdi, 4 + 2 * n);
    if (s32 <= 32'hffff) bdi = min_int(bdi, 4 + 4 * n);
    if (s16 <= 16'hff) bdi = min_int(bdi, 2 + 4 * n);
    case (cfg_mode)
      MODE_FPC: enc = fpc;
      MODE_BDI: enc = bdi;
      default: enc = min_int(fpc, bdi);
    endcase

    // first slot in order whose size is below the block and holds the result
    alloc = blk;
    slot = 0;
    found = 1'b0;
    if (enc < blk) begin
      cnt = (cfg_count > MAX_TARGETS) ? MAX_TARGETS : int'(cfg_count);
      for (int i = 0; i < cnt; i++) begin
        if (!found && cfg_target[i] < blk && enc <= cfg_target[i]) begin
          alloc = cfg_target[i];
          slot = i;
          found = 1'b1;
        end
      end
    end
    res.enc = SIZE_W'(enc);
    res.alloc = SIZE_W'(alloc);
    res.slot = SLOT_W'(slot);
    res.fits = (alloc < blk);
    expected_sizes = {expected_sizes, res};
    blk_words = 0;
  endtask

  // valid stays high after the transfer; gaps and wait_drained lower it
  task automatic send_word(input logic [63:0] w, input logic mark);
    while ($urandom_range(99) < send_idle_pct) begin
      word_valid <= 1'b0;
      @(posedge clk);
    end
    word_valid <= 1'b1;
    data_word <= w;
    last_word <= mark;
    do @(posedge clk); while (word_stall);
    predict_word(w, mark);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TGT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SIZE_MODE: cfg_mode = val[MODE_W-1:0];
      REG_TARGET_COUNT: cfg_count = val[COUNT_W-1:0];
      default: begin
        if (idx >= REG_TARGET_0 && idx < REG_TARGET_END) cfg_target[idx - REG_TARGET_0] = val;
      end
    endcase
  endtask

  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count,
                            input logic [TGT_W-1:0] t0, input logic [TGT_W-1:0] t1,
                            input logic [TGT_W-1:0] t2, input logic [TGT_W-1:0] t3);
    write_reg(REG_SIZE_MODE, TGT_W'(mode));
    write_reg(REG_TARGET_COUNT, TGT_W'(count));
    write_reg(REG_TARGET_0, t0);
    write_reg(REG_TARGET_0 + 3'd1, t1);
    write_reg(REG_TARGET_0 + 3'd2, t2);
    write_reg(REG_TARGET_0 + 3'd3, t3);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    word_valid <= 1'b0;
    while (expected_sizes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_sizes.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_sizes.size()));
      expected_sizes.delete();
    end
    // results still in flight after the last expected one
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    size_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_sizes.size() == 0) begin
        report_mismatch($sformatf("unexpected result enc=%0d alloc=%0d slot=%0d fits=%0d",
                                  enc_size, alloc_size, target_slot, fits_target));
      end else begin
        want = expected_sizes.pop_front();
        if (enc_size !== want.enc)
          report_mismatch($sformatf("enc_size %0d, want %0d", enc_size, want.enc));
        if (alloc_size !== want.alloc)
          report_mismatch($sformatf("alloc_size %0d, want %0d",
                                    alloc_size, want.alloc));
        if (target_slot !== want.slot)
          report_mismatch($sformatf("target_slot %0d, want %0d", target_slot, want.slot));
        if (fits_target !== want.fits)
          report_mismatch($sformatf("fits_target %0d, want %0d", fits_target, want.fits));
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one 32-bit half drawn from the frequent patterns
  function automatic logic [31:0] pattern_half();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return '0;
      1: return {{28{r[3]}}, r[3:0]};
      2: return {4{r[7:0]}};
      3: return {{24{r[7]}}, r[7:0]};
      4: return {{16{r[15]}}, r[15:0]};
      5: return {r[31:16], 16'h0000};
      6: return {{8{r[23]}}, r[23:16], {8{r[7]}}, r[7:0]};
      default: return r;
    endcase
  endfunction

  function automatic logic [63:0] block_word(input word_kind_e kind, input logic [63:0] base,
                                             input int span);
    logic [63:0] m;
    logic [63:0] r;
    m = (span >= 64) ? '1 : ((64'd1 << span) - 64'd1);
    r = rand64();
    case (kind)
      K_ZERO: return '0;
      K_EQUAL: return base;
      K_DELTA: return base + (r & m);
      K_LANE32: return {base[31:0] + (r[63:32] & m[31:0]), base[31:0] + (r[31:0] & m[31:0])};
      K_LANE16: return {base[15:0] + (r[63:48] & m[15:0]), base[15:0] + (r[47:32] & m[15:0]),
                        base[15:0] + (r[31:16] & m[15:0]), base[15:0] + (r[15:0] & m[15:0])};
      K_PATTERN: return {pattern_half(), pattern_half()};
      default: return r;
    endcase
  endfunction

  // mostly well-formed blocks of one kind, some with stray words or no closing mark
  task automatic send_random_block(output int len);
    word_kind_e  kind;
    logic [63:0] base, w;
    int          span;
    bit          mark;
    kind = word_kind_e'($urandom_range(6));
    len = $urandom_range(1, WORDS_PER_BLOCK);
    mark = ($urandom_range(9) != 0);
    if (!mark) len = WORDS_PER_BLOCK;
    base = rand64();
    if ($urandom_range(3) == 0) base = '1 - 64'($urandom_range(300));
    span = $urandom_range(1, 34);
    for (int i = 0; i < len; i++) begin
      w = block_word(kind, base, span);
      if ($urandom_range(19) == 0) w = rand64();
      send_word(w, mark && (i == len - 1));
    end
  endtask

  task automatic random_config();
    logic [TGT_W-1:0] t [MAX_TARGETS];
    if ($urandom_range(1) == 0) begin
      t[0] = TGT_W'($urandom_range(1, 15));
      t[1] = t[0] + TGT_W'($urandom_range(1, 15));
      t[2] = t[1] + TGT_W'($urandom_range(1, 15));
      t[3] = t[2] + TGT_W'($urandom_range(1, 18));
    end else begin
      foreach (t[i]) t[i] = TGT_W'($urandom_range(1, 63));
    end
    set_config(MODE_W'($urandom_range(3)), COUNT_W'($urandom_range(7)), t[0], t[1], t[2], t[3]);
  endtask

  // defaults after reset: FPC sizing and no targets; the unmapped index is ignored
  task automatic test_reset_defaults();
    write_reg(REG_TARGET_END, 6'h3f);
    cfg_valid <= 1'b0;
    send_word('0, 1'b1);
    send_word('1, 1'b1);
    wait_drained();
  endtask

  // hybrid sizing, too many targets, out-of-order and oversized targets
  task automatic test_block_shapes();
    set_config(MODE_MIN, 3'd7, 6'd63, 6'd8, 6'd40, 6'd16);
    // eight words with no closing mark close the block anyway
    for (int i = 0; i < WORDS_PER_BLOCK; i++)
      send_word(64'h8000_0000_0000_0010 + 64'(i * 3), 1'b0);
    send_word(64'hffff_ffff_ffff_ffff, 1'b1);
    send_word(64'h0123_4567_89ab_cdef, 1'b0);
    send_word(64'h0123_4567_89ab_cdef, 1'b1);
    // incompressible block: encoded size reaches the block size
    send_word(64'h5a3c_96e1_0f87_d24b, 1'b0);
    send_word(64'hc3a5_1e69_f00f_b4d2, 1'b0);
    send_word(64'h17e8_a55a_6b94_c33c, 1'b1);
    wait_drained();
  endtask

  task automatic test_size_modes();
    set_config(MODE_BDI, 3'd4, 6'd1, 6'd9, 6'd10, 6'd63);
    send_word('0, 1'b0);
    send_word('0, 1'b1);
    wait_drained();
    // the spare mode code acts as the hybrid minimum
    set_config(MODE_SPARE, 3'd2, 6'd63, 6'd63, 6'd63, 6'd63);
    send_word(64'h1234_1240_1250_1266, 1'b0);
    send_word(64'h12ff_1234_1200_12aa, 1'b1);
    wait_drained();
  endtask

  // registers are read after the block closes, not when it opens
  task automatic test_config_mid_block();
    set_config(MODE_FPC, 3'd1, 6'd20, 6'd1, 6'd1, 6'd1);
    send_word(64'h0000_0007_0000_0003, 1'b0);
    word_valid <= 1'b0;
    write_reg(REG_SIZE_MODE, TGT_W'(MODE_BDI));
    cfg_valid <= 1'b0;
    send_word(64'h0000_0007_0000_0005, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int sent, len;
    repeat (4) begin
      random_config();
      sent = 0;
      while (sent < 58) begin
        send_random_block(len);
        sent += len;
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_block_shapes();
    test_size_modes();
    test_config_mid_block();
    test_random_traffic();
    send_idle_pct = 57;
    recv_idle_pct = 12;
    test_random_traffic();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
rtl/lcse_pkg.sv
rtl/lcse_lane.sv
rtl/lcse_accum.sv
rtl/lcse_final.sv
rtl/line_compressed_size_estimator.sv
test/tb_top.sv
